/* design/gffrp_pkg.sv */
`default_nettype none
package gffrp_pkg;
  localparam int unsigned MAX_COLS_DEF = 64;
  localparam int unsigned MAX_ROWS_DEF = 256;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_WIDE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVW,
    S_DIVH,
    S_CHECK,
    S_SCAN,
    S_RDWAIT,
    S_TEST,
    S_MARK,
    S_MULX,
    S_MULY,
    S_MULW,
    S_MULH,
    S_MULU,
    S_MULV,
    S_CLEAR
  } state_t;
endpackage
`default_nettype wire

/* design/grid_first_fit_rect_placer.sv */
`default_nettype none
// Grid first-fit rectangle placer.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready follows !busy.
//   Index 0 cell_scale, 1 grid_width, 2 start_height (also reloads the grown height).
// Request: pulse start with in_image_width/in_image_height while busy is low.
// Result: out_strobe is high for one cycle with status, position, size and used extent.
//   The receiver cannot stall; every result is delivered in its strobe cycle.
// Sequence: two serial divisions (width, then height) and a check state, then a scan
//   that reads one bitmap row at a time through a single memory port: each window
//   position tests its rows in turn and moves on at the first occupied row, and every
//   growth of the height restarts the scan at the top row. A free window is then read
//   again and marked row by row; multiply states for x, y, width, height and the used
//   extent follow and the strobe comes in the cycle after them. An error found at the
//   check skips the scan, and any error skips the position and size multiplies.
// Throughput: one request in flight; busy is low again in the strobe cycle.
// Reset: a clearing pass writes zero to every bitmap row in turn; busy is high meanwhile.
module grid_first_fit_rect_placer #(
  parameter int unsigned MAX_COLS = gffrp_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = gffrp_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [14:0] in_image_width,
  input  wire logic [14:0] in_image_height,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [13:0]      out_place_x,
  output logic [15:0]      out_place_y,
  output logic [14:0]      out_place_width,
  output logic [16:0]      out_place_height,
  output logic [14:0]      out_used_width,
  output logic [16:0]      out_used_height
);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HW = $clog2(MAX_ROWS + 1) + 2;
  localparam int CW = 7;

  gffrp_pkg::state_t state_r, state_nxt;

  logic [8:0]  scale_r;
  logic [6:0]  gwidth_r;
  logic [HW-1:0] grown_r, height_r;
  logic [6:0]  maxr_r;
  logic [HW-1:0] maxb_r;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_r;

  logic [14:0] div_q_r;
  logic [8:0]  div_rem_r;
  logic [3:0]  div_cnt_r;
  logic [15:0] w_r, h_r;
  logic [6:0]  x_r;
  logic [HW-1:0] y_r, r_r;
  logic [RW:0] clr_r;
  logic        found_r;

  logic [8:0]  s_eff;
  logic [6:0]  gw_eff;
  logic [MAX_COLS-1:0] mask;
  logic [9:0]  rem_sh;
  logic [14:0] q_step;
  logic [8:0]  rem_step;
  logic        div_last, bad_size, chk_full, scan_over, grow_full, win_end;
  logic [15:0] mul_a;
  logic [25:0] mul_p;
  logic        do_read, do_write;
  logic [RW-1:0] addr;

  assign s_eff  = (scale_r == 9'd0) ? 9'd1 : scale_r;
  assign gw_eff = (gwidth_r > CW'(MAX_COLS)) ? CW'(MAX_COLS) : gwidth_r;
  assign cfg_ready = ~busy;

  always_comb begin
    mask = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (i >= int'(x_r) && i < int'(x_r) + int'(w_r)) mask[i] = 1'b1;
    end
  end

  assign rem_sh = {div_rem_r, div_q_r[14]};

  always_comb begin
    if (rem_sh >= 10'(s_eff)) begin
      rem_step = 9'(rem_sh - 10'(s_eff));
      q_step = {div_q_r[13:0], 1'b1};
    end else begin
      rem_step = rem_sh[8:0];
      q_step = {div_q_r[13:0], 1'b0};
    end
  end

  assign div_last  = (div_cnt_r == 4'd14);
  assign bad_size  = (w_r == 16'd0) || (h_r == 16'd0) || (w_r > 16'(gw_eff));
  assign chk_full  = (32'(grown_r) < 32'(h_r)) && (32'(h_r) > 32'(MAX_ROWS));
  assign scan_over = (32'(y_r) + 32'(h_r) > 32'(height_r));
  assign grow_full = (32'(height_r) + 32'(h_r) > 32'(MAX_ROWS));
  assign win_end   = (r_r == y_r + HW'(h_r)) || (r_r >= HW'(MAX_ROWS));

  assign mul_a = (state_r == gffrp_pkg::S_MULX) ? 16'(x_r) :
                 (state_r == gffrp_pkg::S_MULY) ? 16'(y_r) :
                 (state_r == gffrp_pkg::S_MULW) ? w_r :
                 (state_r == gffrp_pkg::S_MULH) ? h_r :
                 (state_r == gffrp_pkg::S_MULU) ? 16'(maxr_r) : 16'(maxb_r);
  assign mul_p = 26'(mul_a) * 26'(s_eff);

  assign do_read = (state_r == gffrp_pkg::S_SCAN);
  assign do_write = (state_r == gffrp_pkg::S_MARK) || (state_r == gffrp_pkg::S_CLEAR);
  assign addr = (state_r == gffrp_pkg::S_CLEAR) ? clr_r[RW-1:0] : RW'(r_r);

  always_ff @(posedge clk) begin
    if (do_write) mem[addr] <= (state_r == gffrp_pkg::S_CLEAR) ? '0 : (rdata_r | mask);
    if (do_read) rdata_r <= mem[addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gffrp_pkg::S_IDLE:   if (start) state_nxt = gffrp_pkg::S_DIVW;
      gffrp_pkg::S_DIVW:   if (div_last) state_nxt = gffrp_pkg::S_DIVH;
      gffrp_pkg::S_DIVH:   if (div_last) state_nxt = gffrp_pkg::S_CHECK;
      gffrp_pkg::S_CHECK:  state_nxt = (bad_size || chk_full) ? gffrp_pkg::S_MULU :
                                                               gffrp_pkg::S_SCAN;
      gffrp_pkg::S_SCAN: begin
        if (found_r) begin
          state_nxt = win_end ? gffrp_pkg::S_MULX : gffrp_pkg::S_RDWAIT;
        end else if (scan_over) begin
          state_nxt = grow_full ? gffrp_pkg::S_MULU : gffrp_pkg::S_SCAN;
        end else if (!win_end) begin
          state_nxt = gffrp_pkg::S_RDWAIT;
        end
      end
      gffrp_pkg::S_RDWAIT: state_nxt = gffrp_pkg::S_TEST;
      gffrp_pkg::S_TEST:   state_nxt = found_r ? gffrp_pkg::S_MARK : gffrp_pkg::S_SCAN;
      gffrp_pkg::S_MARK:   state_nxt = gffrp_pkg::S_SCAN;
      gffrp_pkg::S_MULX:   state_nxt = gffrp_pkg::S_MULY;
      gffrp_pkg::S_MULY:   state_nxt = gffrp_pkg::S_MULW;
      gffrp_pkg::S_MULW:   state_nxt = gffrp_pkg::S_MULH;
      gffrp_pkg::S_MULH:   state_nxt = gffrp_pkg::S_MULU;
      gffrp_pkg::S_MULU:   state_nxt = gffrp_pkg::S_MULV;
      gffrp_pkg::S_MULV:   state_nxt = gffrp_pkg::S_IDLE;
      gffrp_pkg::S_CLEAR:  if (clr_r == (RW+1)'(MAX_ROWS - 1)) state_nxt = gffrp_pkg::S_IDLE;
      default:             state_nxt = gffrp_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != gffrp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
      state_r <= gffrp_pkg::S_CLEAR;
      clr_r <= '0;
      scale_r <= 9'd1;
      gwidth_r <= 7'd64;
      grown_r <= (HW'(64) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(64);
      maxr_r <= '0;
      maxb_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_strobe <= (state_r == gffrp_pkg::S_MULV);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gffrp_pkg::REG_SCALE:  scale_r <= cfg_data;
          gffrp_pkg::REG_WIDTH:  gwidth_r <= cfg_data[6:0];
          gffrp_pkg::REG_HEIGHT: begin
            grown_r <= (HW'(cfg_data) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(cfg_data);
          end
          default: ;
        endcase
      end
      unique case (state_r) inside
        gffrp_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        gffrp_pkg::S_IDLE: if (start) begin
          div_q_r <= in_image_width;
          h_r <= 16'(in_image_height);
          div_rem_r <= '0;
          div_cnt_r <= '0;
        end
        gffrp_pkg::S_DIVW, gffrp_pkg::S_DIVH: begin
          if (div_last) begin
            div_cnt_r <= '0;
            div_rem_r <= '0;
            if (state_r == gffrp_pkg::S_DIVW) begin
              w_r <= 16'(q_step) + 16'(rem_step != 9'd0);
              div_q_r <= h_r[14:0];
            end else begin
              h_r <= 16'(q_step) + 16'(rem_step != 9'd0);
            end
          end else begin
            div_cnt_r <= div_cnt_r + 1'b1;
            div_q_r <= q_step;
            div_rem_r <= rem_step;
          end
        end
        gffrp_pkg::S_CHECK: begin
          x_r <= '0;
          y_r <= '0;
          r_r <= '0;
          found_r <= 1'b0;
          height_r <= (32'(grown_r) < 32'(h_r)) ? HW'(h_r) : grown_r;
          out_status <= bad_size ? gffrp_pkg::ST_WIDE : gffrp_pkg::ST_FULL;
        end
        gffrp_pkg::S_SCAN: begin
          if (found_r) begin
            if (win_end) begin
              grown_r <= height_r;
              if (7'(x_r + w_r) > maxr_r) maxr_r <= 7'(x_r + w_r);
              if (y_r + HW'(h_r) > maxb_r) maxb_r <= y_r + HW'(h_r);
              out_status <= gffrp_pkg::ST_PLACED;
            end
          end else if (scan_over) begin
            if (grow_full) begin
              out_status <= gffrp_pkg::ST_FULL;
            end else begin
              height_r <= height_r + HW'(h_r);
              y_r <= '0; x_r <= '0; r_r <= '0;
            end
          end else if (win_end) begin
            found_r <= 1'b1;
            r_r <= y_r;
          end
        end
        gffrp_pkg::S_TEST: begin
          if (!found_r) begin
            if ((rdata_r & mask) != '0) begin
              if (16'(x_r) + w_r + 16'd1 > 16'(gw_eff)) begin
                x_r <= '0;
                y_r <= y_r + 1'b1;
                r_r <= y_r + 1'b1;
              end else begin
                x_r <= x_r + 1'b1;
                r_r <= y_r;
              end
            end else begin
              r_r <= r_r + 1'b1;
            end
          end
        end
        gffrp_pkg::S_MARK: r_r <= r_r + 1'b1;
        gffrp_pkg::S_MULX: out_place_x <= mul_p[13:0];
        gffrp_pkg::S_MULY: out_place_y <= mul_p[15:0];
        gffrp_pkg::S_MULW: out_place_width <= mul_p[14:0];
        gffrp_pkg::S_MULH: out_place_height <= mul_p[16:0];
        gffrp_pkg::S_MULU: begin
          out_used_width <= mul_p[14:0];
          if (out_status != gffrp_pkg::ST_PLACED) begin
            out_place_x <= '0; out_place_y <= '0;
            out_place_width <= '0; out_place_height <= '0;
          end
        end
        gffrp_pkg::S_MULV: out_used_height <= mul_p[16:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == gffrp_pkg::S_IDLE) else $error("strobe outside idle");
  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && start) |=> state_r != gffrp_pkg::S_DIVW || $past(state_r) == gffrp_pkg::S_DIVW)
    else $error("start taken while busy");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status != 2'd3) else $error("bad status");
`endif
endmodule
`default_nettype wire

/* tb/grid_first_fit_rect_placer_tb.sv */
`timescale 1ns / 100ps
module grid_first_fit_rect_placer_tb;

  localparam int unsigned ROWS = 256;
  localparam int unsigned COLS = 64;
  localparam int unsigned CYCLE_LIMIT = 100000000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [8:0]  data;
    logic [14:0] iw;
    logic [14:0] ih;
  } word_t;

  typedef struct {
    logic [1:0]  status;
    logic [13:0] place_x;
    logic [15:0] place_y;
    logic [14:0] place_width;
    logic [16:0] place_height;
    logic [14:0] used_width;
    logic [16:0] used_height;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [14:0] in_image_width = '0;
  logic [14:0] in_image_height = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [13:0] out_place_x;
  logic [15:0] out_place_y;
  logic [14:0] out_place_width;
  logic [16:0] out_place_height;
  logic [14:0] out_used_width;
  logic [16:0] out_used_height;

  grid_first_fit_rect_placer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_image_width(in_image_width), .in_image_height(in_image_height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_strobe(out_strobe), .out_status(out_status),
    .out_place_x(out_place_x), .out_place_y(out_place_y),
    .out_place_width(out_place_width), .out_place_height(out_place_height),
    .out_used_width(out_used_width), .out_used_height(out_used_height)
  );

  logic [63:0] occ_map [ROWS];
  int unsigned scale_r = 1, width_r = 64, start_r = 64;
  int unsigned grown_rows = 64, right_max = 0, bottom_max = 0;

  word_t      pend_q [$];
  placement_t placement_q [$];
  int         errors = 0, n_placed = 0, n_wide = 0, n_full = 0;
  int unsigned cycles = 0;
  int         gap_left = 0, burst_left = 0, quiet = 0;
  bit         go, wrote;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] span(int unsigned x, int unsigned w);
    logic [63:0] m;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    return m << x;
  endfunction

  function automatic bit window_clear(int unsigned x, int unsigned y, int unsigned w,
                                      int unsigned h);
    logic [63:0] m;
    m = span(x, w);
    for (int unsigned r = y; r < y + h; r++)
      if (r < ROWS && (occ_map[r] & m) != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void write_reg(logic [1:0] idx, logic [8:0] data);
    case (idx)
      gffrp_pkg::REG_SCALE: scale_r = 32'(data);
      gffrp_pkg::REG_WIDTH: width_r = 32'(data[6:0]);
      gffrp_pkg::REG_HEIGHT: begin
        start_r = 32'(data);
        grown_rows = (start_r > ROWS) ? ROWS : start_r;
      end
      default: ;
    endcase
  endfunction

  function automatic placement_t place_rect(int unsigned iw, int unsigned ih);
    placement_t  r;
    int unsigned s, gw, w, h, ht, px, py;
    bit          found, full;
    s = (scale_r == 0) ? 1 : scale_r;
    gw = (width_r > COLS) ? COLS : width_r;
    w = (iw + s - 1) / s;
    h = (ih + s - 1) / s;
    r = '{default: '0};
    found = 0;
    full = 0;
    px = 0;
    py = 0;
    if (w == 0 || h == 0 || w > gw) begin
      r.status = gffrp_pkg::ST_WIDE;
    end else begin
      ht = grown_rows;
      while (!found && !full) begin
        if (ht < h) begin
          ht = h;
        end else begin
          for (int unsigned y = 0; !found && y + h <= ht; y++)
            for (int unsigned x = 0; !found && x + w <= gw; x++)
              if (window_clear(x, y, w, h)) begin
                px = x;
                py = y;
                found = 1;
              end
          if (!found) ht += h;
        end
        if (!found && ht > ROWS) full = 1;
      end
      if (found) begin
        for (int unsigned k = py; k < py + h && k < ROWS; k++) occ_map[k] |= span(px, w);
        grown_rows = ht;
        if (px + w > right_max) right_max = px + w;
        if (py + h > bottom_max) bottom_max = py + h;
        r.status = gffrp_pkg::ST_PLACED;
        r.place_x = 14'(px * s);
        r.place_y = 16'(py * s);
        r.place_width = 15'(w * s);
        r.place_height = 17'(h * s);
      end else begin
        r.status = gffrp_pkg::ST_FULL;
      end
    end
    r.used_width = 15'(right_max * s);
    r.used_height = 17'(bottom_max * s);
    return r;
  endfunction

  function automatic void add_item(int unsigned iw, int unsigned ih);
    word_t t;
    t = '{is_cfg: 1'b0, idx: '0, data: '0, iw: 15'(iw), ih: 15'(ih)};
    pend_q.push_back(t);
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [8:0] data);
    word_t t;
    t = '{is_cfg: 1'b1, idx: idx, data: data, iw: '0, ih: '0};
    pend_q.push_back(t);
  endfunction

  function automatic int unsigned cells_px(int unsigned c, int unsigned s);
    return (c - 1) * s + $urandom_range(s, 1);
  endfunction

  function automatic void add_random(int unsigned s, int unsigned gw, int n);
    int unsigned k, lo, cap;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99, 0);
      cap = (gw < 3) ? gw : 3;
      if (gw == 0) begin
        add_item($urandom_range(32767, 0), $urandom_range(32767, 0));
      end else if (k < 50) begin
        add_item(cells_px($urandom_range(cap, 1), s), cells_px($urandom_range(3, 1), s));
      end else if (k < 65 && gw * s + 1 <= 32767) begin
        lo = gw * s + 1;
        add_item($urandom_range(32767, lo), $urandom_range(32767, 0));
      end else if (k < 80 && ROWS * s + 1 <= 32767) begin
        lo = ROWS * s + 1;
        add_item(cells_px($urandom_range(cap, 1), s), $urandom_range(32767, lo));
      end else if ($urandom_range(1, 0) == 0) begin
        add_item(0, $urandom_range(32767, 0));
      end else begin
        add_item($urandom_range(32767, 0), 0);
      end
    end
  endfunction

  function automatic void add_phase(int unsigned sc, int unsigned gw, int unsigned sh, int n);
    int unsigned es, eg;
    add_reg(gffrp_pkg::REG_SCALE, 9'(sc));
    add_reg(gffrp_pkg::REG_WIDTH, 9'(gw));
    add_reg(gffrp_pkg::REG_HEIGHT, 9'(sh));
    es = (sc == 0) ? 1 : sc;
    eg = (gw > COLS) ? COLS : gw;
    add_random(es, eg, n);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      go = start && !busy;
      wrote = cfg_valid && cfg_ready;
      if (go) placement_q.push_back(place_rect(32'(in_image_width), 32'(in_image_height)));
      if (wrote) write_reg(cfg_index, cfg_data);
      quiet <= (placement_q.size() == 0 && !busy && !start && !cfg_valid) ? quiet + 1 : 0;
      if ((start && !go) || (cfg_valid && !wrote)) begin
        // hold the word until it is taken
      end else if (pend_q.size() != 0 && pend_q[0].is_cfg) begin
        start <= 1'b0;
        if (!go && !wrote && quiet >= 4) begin
          cfg_valid <= 1'b1;
          cfg_index <= pend_q[0].idx;
          cfg_data <= pend_q[0].data;
          void'(pend_q.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end else if (gap_left != 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() != 0) begin
        start <= 1'b1;
        cfg_valid <= 1'b0;
        in_image_width <= pend_q[0].iw;
        in_image_height <= pend_q[0].ih;
        void'(pend_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(24, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    placement_t e;
    if (rst_n && out_strobe) begin
      if (placement_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, status %0d", $time, out_status);
      end else begin
        e = placement_q.pop_front();
        check_field("status", 32'(e.status), 32'(out_status));
        check_field("place_x", 32'(e.place_x), 32'(out_place_x));
        check_field("place_y", 32'(e.place_y), 32'(out_place_y));
        check_field("place_width", 32'(e.place_width), 32'(out_place_width));
        check_field("place_height", 32'(e.place_height), 32'(out_place_height));
        check_field("used_width", 32'(e.used_width), 32'(out_used_width));
        check_field("used_height", 32'(e.used_height), 32'(out_used_height));
        case (e.status)
          gffrp_pkg::ST_PLACED: n_placed++;
          gffrp_pkg::ST_WIDE: n_wide++;
          default: n_full++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ROWS; i++) occ_map[i] = '0;
    add_item(1, 1);
    add_item(64, 1);
    add_item(65, 1);
    add_item(0, 5);
    add_item(5, 0);
    add_item(0, 0);
    add_item(32767, 32767);
    add_item(1, 32767);
    add_item(1, 300);
    add_item(8, 70);
    add_item(10, 200);
    add_item(16384, 1);
    add_item(16, 16);
    add_item(3, 2);
    add_phase(256, 1, 1, 30);
    add_reg(REG_UNUSED, 9'h1ff);
    add_phase(0, 127, 511, 300);
    add_phase(3, 7, 256, 300);
    add_phase(17, 0, 100, 100);
    add_phase(256, 64, 1, 10);
    add_item(16384, 256);
    add_item(16384, 16384);
    add_item(16385, 1);
    add_random(256, 64, 290);
    add_phase(1, 64, 64, 300);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pend_q.size() != 0 || start || cfg_valid || placement_q.size() != 0 || busy)
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d requests: %0d placed, %0d too wide or empty, %0d out of rows,",
             n_placed + n_wide + n_full, n_placed, n_wide, n_full);
    $display("over six register settings including scale, width and height extremes.");
    if (errors == 0 && placement_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
